### design/bdlg_pkg.sv
// shared types and constants for the box downsample luma glyph block
`default_nettype none
package bdlg_pkg;
  localparam int unsigned LumaR = 13933;
  localparam int unsigned LumaG = 46871;
  localparam int unsigned LumaB = 4732;
  localparam logic [1:0] RegScale = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic [3:0] level;
    logic [6:0] glyph;
    logic       row_end;
  } res_t;

  function automatic logic [6:0] ramp_char(input logic [3:0] lvl);
    case (lvl)
      4'd0: ramp_char = 7'd32;
      4'd1: ramp_char = 7'd46;
      4'd2: ramp_char = 7'd58;
      4'd3: ramp_char = 7'd45;
      4'd4: ramp_char = 7'd61;
      4'd5: ramp_char = 7'd43;
      4'd6: ramp_char = 7'd42;
      4'd7: ramp_char = 7'd35;
      4'd8: ramp_char = 7'd37;
      default: ramp_char = 7'd64;
    endcase
  endfunction
endpackage
`default_nettype wire

### design/bdlg_stream_if.sv
// valid/ready channel interface
`default_nettype none
interface bdlg_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/box_downsample_luma_glyph.sv
// box downsample with luma quantizer, top level
// pixels arrive as beats on pix_in (red, green, blue, frame_start) in raster
// order; results leave on res_out as {avg_red, avg_green, avg_blue, level,
// glyph, row_end}. config writes go through cfg_we/cfg_index/cfg_data while
// idle. each block of scale columns by 2*scale rows gives one result.
// after reset or a config write the blocks per row are recomputed by a
// 12-step serial divider; pix_in.ready stays low until it has finished.
// an input beat is read-modify-written into the column-sum memory (read,
// then add and write), after which a pixel that ends no block is done.
// a pixel that closes a block runs three serial divides of 18 steps each,
// a luma multiply stage and a level stage, and then waits until the output
// register is free; no new beat is taken before its result is loaded there.
// the result sits in an output register; the next pixel is accepted while it
// waits, but a further finished block waits until the receiver takes it.
// reset (rst, synchronous) clears position counters and config to defaults;
// the sum memory is not cleared, the first pixel of each block overwrites it.
`default_nettype none
module box_downsample_luma_glyph #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bdlg_stream_if.sink   pix_in,
  bdlg_stream_if.source res_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int NMAX = 2 * MAX_SCALE * MAX_SCALE;
  localparam int DW = $clog2(NMAX + 1);
  localparam int SUMW = 8 + DW;
  localparam int BW = CW + SW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRmw = 3'd1;
  localparam logic [2:0] StDiv = 3'd2;
  localparam logic [2:0] StLuma = 3'd3;
  localparam logic [2:0] StLevel = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [4:0]  block_scale;
  logic [11:0] frame_width, frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_scale <= 5'd1;
      frame_width <= 12'd640;
      frame_height <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlg_pkg::RegScale: block_scale <= cfg_data[4:0];
        bdlg_pkg::RegWidth: frame_width <= cfg_data;
        bdlg_pkg::RegHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped config
  logic [SW-1:0] s;
  logic [CW-1:0] w;
  logic [11:0]   h;
  always_comb begin
    if (block_scale == 5'd0) s = SW'(1);
    else if (32'(block_scale) > MAX_SCALE) s = SW'(MAX_SCALE);
    else s = SW'(block_scale);
    if (frame_width == 12'd0) w = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w = CW'(MAX_WIDTH);
    else w = CW'(frame_width);
    h = (frame_height == 12'd0) ? 12'd1 : frame_height;
  end
  logic [SW:0] rpb;
  assign rpb = {s, 1'b0};

  // whole blocks per row, recomputed after reset and each config write
  logic          geo_start, geo_ok, geo_busy, geo_done;
  logic [CW-1:0] blocks;
  logic [BW-1:0] blk_cols;
  bdlg_divider #(.NW(CW), .DW(SW)) u_geo (
    .clk(clk), .rst(rst), .start(geo_start), .num(w), .den(s),
    .busy(geo_busy), .done(geo_done), .quo(blocks)
  );
  assign blk_cols = BW'(blocks) * BW'(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      geo_start <= 1'b1;
      geo_ok <= 1'b0;
    end else begin
      geo_start <= cfg_we;
      if (cfg_we || geo_start) geo_ok <= 1'b0;
      else if (geo_done) geo_ok <= 1'b1;
    end
  end

  // counters, with frame_start applied
  logic [CW-1:0] pixel_col, pc, pixel_col_next;
  logic [11:0]   pixel_row, pr, pixel_row_next;
  logic [SW-1:0] sub_col, sc, sub_col_next;
  logic [CW-1:0] out_col, oc, out_col_next;
  logic [SW:0]   sub_row, sr, sub_row_next;
  bdlg_pkg::pix_t pix;
  assign pix = pix_in.data;

  always_comb begin
    if (pix.frame_start) begin
      pc = '0; pr = '0; sc = '0; oc = '0; sr = '0;
    end else begin
      pc = pixel_col; pr = pixel_row; sc = sub_col; oc = out_col; sr = sub_row;
    end
  end

  always_comb begin
    if (sc + 1'b1 >= s) begin
      sub_col_next = '0; out_col_next = oc + 1'b1;
    end else begin
      sub_col_next = sc + 1'b1; out_col_next = oc;
    end
    pixel_col_next = pc + 1'b1; pixel_row_next = pr; sub_row_next = sr;
    if ({1'b0, pc} + 1'b1 >= {1'b0, w}) begin
      pixel_col_next = '0; sub_col_next = '0; out_col_next = '0;
      sub_row_next = (sr + 1'b1 >= rpb) ? '0 : sr + 1'b1;
      if (pr + 1'b1 >= h) begin
        pixel_row_next = '0; sub_row_next = '0;
      end else begin
        pixel_row_next = pr + 1'b1;
      end
    end
  end

  logic in_block, closes, last_blk;
  always_comb begin
    in_block = (BW'(pc) < blk_cols) && (oc < blocks) && (32'(oc) < MAX_WIDTH);
    closes = in_block && (sr >= rpb - 1'b1) && (sc >= s - 1'b1);
    last_blk = ({1'b0, oc} + 1'b1 >= {1'b0, blocks});
  end

  logic [2:0] state;
  logic       acc;
  logic       res_valid;
  bdlg_pkg::res_t res_q;
  assign pix_in.ready = (state == StIdle) && geo_ok && !geo_busy;
  assign acc = pix_in.valid && pix_in.ready;

  // memory
  logic [3*SUMW-1:0] mem [MAX_WIDTH];
  logic [3*SUMW-1:0] rd;
  logic [AW-1:0]     addr_q;
  logic [7:0]        r_q, g_q, b_q;
  logic              first_q, close_q, end_q, wr_q;
  logic [DW-1:0]     n_q;
  logic [SUMW-1:0]   sum_r, sum_g, sum_b;
  logic [3*SUMW-1:0] sum_new;

  always_ff @(posedge clk) begin
    if (acc) rd <= mem[AW'(oc)];
    if (state == StRmw && wr_q) mem[addr_q] <= sum_new;
  end

  always_comb begin
    if (first_q) begin
      sum_r = SUMW'(r_q); sum_g = SUMW'(g_q); sum_b = SUMW'(b_q);
    end else begin
      sum_r = rd[3*SUMW-1:2*SUMW] + SUMW'(r_q);
      sum_g = rd[2*SUMW-1:SUMW] + SUMW'(g_q);
      sum_b = rd[SUMW-1:0] + SUMW'(b_q);
    end
    sum_new = {sum_r, sum_g, sum_b};
  end

  // divider
  logic            dv_start, dv_busy, dv_done;
  logic [SUMW-1:0] dv_num, dv_quo;
  logic [1:0]      ch;
  logic [SUMW-1:0] hold_g, hold_b;
  logic [7:0]      ar, ag, ab;
  bdlg_divider #(.NW(SUMW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(n_q),
    .busy(dv_busy), .done(dv_done), .quo(dv_quo)
  );
  logic [24:0] luma;
  logic [27:0] luma9;
  logic [3:0]  lvl;

  always_comb begin
    dv_start = 1'b0;
    dv_num = sum_r;
    if (state == StRmw && close_q) begin
      dv_start = 1'b1;
    end else if (state == StDiv && dv_done && ch != 2'd2) begin
      dv_start = 1'b1;
      dv_num = (ch == 2'd0) ? hold_g : hold_b;
    end
  end

  // level is the count of multiples of 255 reached by luma*9
  always_comb begin
    lvl = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (luma9 >= 28'(255 * k)) lvl = 4'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == StOut && (!res_valid || res_out.ready)) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      pixel_col <= '0; pixel_row <= '0; sub_col <= '0; out_col <= '0;
      sub_row <= '0;
      ch <= '0;
    end else begin
      case (state)
        StIdle: if (acc) begin
          addr_q <= AW'(oc);
          r_q <= pix.red; g_q <= pix.green; b_q <= pix.blue;
          first_q <= (sr == '0) && (sc == '0);
          wr_q <= in_block;
          close_q <= closes;
          end_q <= last_blk;
          n_q <= DW'(rpb) * DW'(s);
          state <= StRmw;
          pixel_col <= pixel_col_next;
          pixel_row <= pixel_row_next;
          sub_col <= sub_col_next;
          out_col <= out_col_next;
          sub_row <= sub_row_next;
        end
        StRmw: begin
          hold_g <= sum_g; hold_b <= sum_b;
          ch <= '0;
          state <= close_q ? StDiv : StIdle;
        end
        StDiv: if (dv_done) begin
          case (ch)
            2'd0: ar <= dv_quo[7:0];
            2'd1: ag <= dv_quo[7:0];
            default: ab <= dv_quo[7:0];
          endcase
          if (ch == 2'd2) state <= StLuma;
          ch <= ch + 1'b1;
        end
        StLuma: begin
          luma <= 25'((24'(bdlg_pkg::LumaR) * ar + 24'(bdlg_pkg::LumaG) * ag
                  + 24'(bdlg_pkg::LumaB) * ab) >> 16);
          state <= StLevel;
        end
        StLevel: begin
          luma9 <= 28'(luma) * 28'd9;
          state <= StOut;
        end
        StOut: if (!res_valid || res_out.ready) begin
          res_q <= '{avg_red: ar, avg_green: ag, avg_blue: ab, level: lvl,
                     glyph: bdlg_pkg::ramp_char(lvl), row_end: end_q};
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.data = res_q;
endmodule
`default_nettype wire

### design/bdlg_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bdlg_divider #(
  parameter int NW = 19,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW:0]   trial;
  logic [NW-1:0] shreg;

  assign trial = {rem[DW-1:0], shreg[NW-1]} - {1'b0, den};
  assign quo = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= CW'(NW);
      rem <= '0;
      shreg <= num;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial;
        shreg <= {shreg[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], shreg[NW-1]};
        shreg <= {shreg[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### design/bdlg_checker.sv
// port-level checker for the box downsample block, with its bind
`default_nettype none
module bdlg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [35:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("stall");
  a_lvl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[11:8] <= 4'd9) else $error("level");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("reset");
endmodule

bind box_downsample_luma_glyph bdlg_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
);
`default_nettype wire

### test/bdlg_tb_if.sv
`timescale 1ns / 1ps
// testbench timing constants
package bdlg_tb_util_pkg;
  localparam int unsigned TbPeriodNs = 20;
endpackage

### test/box_downsample_luma_glyph_tb.sv
`timescale 1ns / 1ps
// testbench for the box downsample luma glyph block: predicts block averages and glyphs
module box_downsample_luma_glyph_tb;

  class block_scoreboard;
    bdlg_pkg::res_t pending[$];
    int errors;
    logic [4:0] scale;
    logic [11:0] width;
    logic [11:0] height;
    int unsigned col_r[2048];
    int unsigned col_g[2048];
    int unsigned col_b[2048];
    int unsigned pcol, prow, scol, ocol, srow;

    function void reset_state();
      scale = 5'd1; width = 12'd640; height = 12'd480;
      pcol = 0; prow = 0; scol = 0; ocol = 0; srow = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
      if (idx == bdlg_pkg::RegScale) scale = val[4:0];
      else if (idx == bdlg_pkg::RegWidth) width = val;
      else if (idx == bdlg_pkg::RegHeight) height = val;
    endfunction

    function void note_pixel(bdlg_pkg::pix_t p);
      int unsigned s, w, h, blocks, band, sr, sg, sb, n, ar, ag, ab, luma, lvl;
      bdlg_pkg::res_t r;
      if (p.frame_start) begin
        pcol = 0; prow = 0; scol = 0; ocol = 0; srow = 0;
      end
      s = 32'(scale); if (s < 1) s = 1; if (s > 16) s = 16;
      w = 32'(width); if (w < 1) w = 1; if (w > 2048) w = 2048;
      h = 32'(height); if (h < 1) h = 1;
      blocks = w / s;
      band = 2 * s;
      if (pcol < blocks * s && ocol < blocks && ocol < 2048) begin
        if (srow == 0 && scol == 0) begin
          sr = 32'(p.red); sg = 32'(p.green); sb = 32'(p.blue);
        end else begin
          sr = col_r[ocol] + 32'(p.red);
          sg = col_g[ocol] + 32'(p.green);
          sb = col_b[ocol] + 32'(p.blue);
        end
        col_r[ocol] = sr; col_g[ocol] = sg; col_b[ocol] = sb;
        if (srow >= band - 1 && scol >= s - 1) begin
          n = band * s;
          ar = (sr / n) & 255; ag = (sg / n) & 255; ab = (sb / n) & 255;
          luma = (13933 * ar + 46871 * ag + 4732 * ab) >> 16;
          lvl = (luma * 9) / 255;
          if (lvl > 9) lvl = 9;
          r.avg_red = 8'(ar); r.avg_green = 8'(ag); r.avg_blue = 8'(ab);
          r.level = 4'(lvl);
          case (lvl)
            0: r.glyph = 7'(" ");
            1: r.glyph = 7'(".");
            2: r.glyph = 7'(":");
            3: r.glyph = 7'("-");
            4: r.glyph = 7'("=");
            5: r.glyph = 7'("+");
            6: r.glyph = 7'("*");
            7: r.glyph = 7'("#");
            8: r.glyph = 7'("%");
            default: r.glyph = 7'("@");
          endcase
          r.row_end = (ocol + 1 >= blocks);
          pending.push_back(r);
        end
      end
      if (scol + 1 >= s) begin
        scol = 0; ocol++;
      end else scol++;
      if (pcol + 1 >= w) begin
        pcol = 0; scol = 0; ocol = 0;
        if (srow + 1 >= band) srow = 0; else srow++;
        if (prow + 1 >= h) begin
          prow = 0; srow = 0;
        end else prow++;
      end else pcol++;
    endfunction

    task check_block(bdlg_pkg::res_t got);
      bdlg_pkg::res_t exp_r;
      if (pending.size() == 0) begin
        report_err("result with nothing expected");
        return;
      end
      exp_r = pending.pop_front();
      if (got.avg_red !== exp_r.avg_red) report_err("avg_red mismatch");
      if (got.avg_green !== exp_r.avg_green) report_err("avg_green mismatch");
      if (got.avg_blue !== exp_r.avg_blue) report_err("avg_blue mismatch");
      if (got.level !== exp_r.level) report_err("level mismatch");
      if (got.glyph !== exp_r.glyph) report_err("glyph mismatch");
      if (got.row_end !== exp_r.row_end) report_err("row_end mismatch");
    endtask

    task report_err(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = bdlg_pkg::RegScale;
  logic [11:0] cfg_data = 0;
  int send_idle = 0;
  int recv_idle = 0;
  block_scoreboard board;

  bdlg_stream_if #(.W($bits(bdlg_pkg::pix_t))) pix_ch ();
  bdlg_stream_if #(.W($bits(bdlg_pkg::res_t))) res_ch ();

  box_downsample_luma_glyph u_dut (
    .clk(clk), .rst(rst), .pix_in(pix_ch.sink), .res_out(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(bdlg_tb_util_pkg::TbPeriodNs / 2) clk = ~clk;

  initial begin
    pix_ch.valid = 0;
    pix_ch.data = '0;
    res_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) board.check_block(bdlg_pkg::res_t'(res_ch.data));
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // valid stays up after the beat until the next pixel or a drain
  task automatic send_pixel(bdlg_pkg::pix_t p);
    if ($urandom_range(99) < send_idle) begin
      pix_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    pix_ch.valid <= 1;
    pix_ch.data <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    board.note_pixel(p);
  endtask

  task automatic drain();
    pix_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_frame(int w, int h, int mode);
    bdlg_pkg::pix_t p;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        p.frame_start = (x == 0 && y == 0);
        case (mode)
          0: begin p.red = 0; p.green = 0; p.blue = 0; end
          1: begin p.red = 255; p.green = 255; p.blue = 255; end
          default: begin
            p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
          end
        endcase
        send_pixel(p);
      end
  endtask

  task automatic run_setting(int s, int w, int h, int frames);
    write_reg(bdlg_pkg::RegScale, 12'(s));
    write_reg(bdlg_pkg::RegWidth, 12'(w));
    write_reg(bdlg_pkg::RegHeight, 12'(h));
    for (int f = 0; f < frames; f++) send_frame(w, h, 2);
    drain();
  endtask

  initial begin
    bdlg_pkg::pix_t p;
    board = new();
    board.reset_state();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 21; recv_idle = 59;
    write_reg(bdlg_pkg::RegScale, 12'd1);
    write_reg(bdlg_pkg::RegWidth, 12'd3);
    write_reg(bdlg_pkg::RegHeight, 12'd2);
    send_frame(3, 2, 0);
    send_frame(3, 2, 1);
    for (int k = 0; k < 6; k++) begin
      p.red = 8'h80 >> k; p.green = 8'h7f; p.blue = 8'hff; p.frame_start = (k == 0);
      send_pixel(p);
    end
    drain();
    write_reg(bdlg_pkg::RegScale, 12'd0);
    write_reg(bdlg_pkg::RegWidth, 12'd0);
    write_reg(bdlg_pkg::RegHeight, 12'd0);
    send_frame(1, 1, 1);
    send_frame(1, 1, 2);
    drain();
    // partial band rows and dropped right columns, wrap without frame_start
    write_reg(bdlg_pkg::RegScale, 12'd2);
    write_reg(bdlg_pkg::RegWidth, 12'd5);
    write_reg(bdlg_pkg::RegHeight, 12'd5);
    for (int k = 0; k < 50; k++) begin
      p.red = 8'($urandom); p.green = 8'($urandom); p.blue = 8'($urandom);
      p.frame_start = 0;
      send_pixel(p);
    end
    drain();
    run_setting(31, 17, 33, 1);
    send_idle = 59; recv_idle = 21;
    run_setting(1, 8, 6, 2);
    run_setting(2, 9, 8, 2);
    run_setting(3, 7, 12, 1);
    send_idle = 0; recv_idle = 0;
    run_setting(1, 40, 2, 1);
    run_setting(2, 12, 8, 2);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("box_downsample_luma_glyph_tb: PASS");
    end else begin
      $display("box_downsample_luma_glyph_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("box_downsample_luma_glyph_tb: FAIL");
    $finish;
  end
endmodule
